// ----- rtl/core/oebs_pkg.sv -----
// Package: sizes, opcodes, control structs and float32 helpers for the bag-sum unit.
`default_nettype none
package oebs_pkg;
   localparam int NumRows = 1024;
   localparam int Dim     = 16;
   localparam int RowW    = $clog2(NumRows);
   localparam int ColW    = (Dim > 1) ? $clog2(Dim) : 1;
   localparam int MemW    = RowW + ColW;
   localparam int MemDepth = NumRows * (1 << ColW);
   localparam int ScanW   = RowW + 1;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_EMIT   = 2'd2;

   localparam logic [31:0] QNAN = 32'h7FC00000;

   typedef struct packed {
      logic          mem_we;
      logic          scan_start;
      logic          scan_step;
      logic          acc_en;
      logic          set_bad;
      logic          emit_load;
      logic          emit_clear;
      logic [ColW-1:0] col;
   } ctrl_type;

   typedef struct packed {
      logic scan_last;
      logic hit;
   } stat_type;

   // Float32 add, round to nearest even, NaN canonicalized.
   function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
      logic        sa, sb, sx, sy, sr;
      logic [7:0]  ea, eb, ex, ey;
      logic [26:0] mx, my, sh;
      logic [27:0] sum;
      logic [7:0]  d;
      logic [9:0]  er;
      logic [4:0]  lz;
      logic [27:0] nm;
      logic        st, rnd;
      logic [24:0] mr;
      logic [31:0] res;
      sa = a[31]; sb = b[31]; ea = a[30:23]; eb = b[30:23];
      res = 32'd0;
      if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) begin
         res = QNAN;
      end else if (ea == 8'hFF && eb == 8'hFF) begin
         res = (sa == sb) ? a : QNAN;
      end else if (ea == 8'hFF) begin
         res = a;
      end else if (eb == 8'hFF) begin
         res = b;
      end else begin
         if ({ea, a[22:0]} >= {eb, b[22:0]}) begin
            sx = sa; ex = ea; mx = {(ea != 0), a[22:0], 3'b0};
            sy = sb; ey = eb; my = {(eb != 0), b[22:0], 3'b0};
         end else begin
            sx = sb; ex = eb; mx = {(eb != 0), b[22:0], 3'b0};
            sy = sa; ey = ea; my = {(ea != 0), a[22:0], 3'b0};
         end
         if (ex == 0) ex = 8'd1;
         if (ey == 0) ey = 8'd1;
         d = ex - ey;
         if (d > 8'd26) begin
            sh = {26'd0, (my != 0)};
         end else begin
            sh = my >> d;
            st = ((my & ((27'd1 << d) - 27'd1)) != 0);
            sh[0] = sh[0] | st;
         end
         sr = sx;
         if (sx == sy) sum = {1'b0, mx} + {1'b0, sh};
         else          sum = {1'b0, mx} - {1'b0, sh};
         if (sum == 0) begin
            res = {(sa & sb), 31'd0};
         end else begin
            er = {2'b0, ex} + 10'd1;
            lz = 5'd0;
            for (int i = 27; i >= 0; i--) begin
               if (sum[i] && lz == 0 && (sum >> (i + 1)) == 0) lz = 5'(27 - i);
            end
            if ({5'd0, lz} >= er) begin
               nm = sum << (er - 10'd1);
               er = 10'd0;
            end else begin
               nm = sum << lz;
               er = er - {5'd0, lz};
            end
            // nm[27] leading, 24 mantissa bits nm[27:4], guard nm[3], sticky nm[2:0]
            rnd = nm[3] && ((nm[2:0] != 0) || nm[4]);
            mr = {1'b0, nm[27:4]} + {24'd0, rnd};
            if (mr[24]) begin
               mr = mr >> 1;
               er = er + 10'd1;
            end else if (er == 0 && mr[23]) begin
               er = 10'd1;
            end
            if (er >= 10'd255) res = {sr, 8'hFF, 23'd0};
            else               res = {sr, er[7:0], mr[22:0]};
         end
      end
      return res;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/core/oebs_stream_if.sv -----
// Interfaces: request and response valid/ready channels.
`default_nettype none
interface oebs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [9:0]  weight_row;
   logic [5:0]  weight_column;
   logic [31:0] weight_value;
   logic [31:0] lookup_index;
   modport source (output valid, operation, weight_row, weight_column, weight_value,
                   lookup_index, input ready);
   modport sink (input valid, operation, weight_row, weight_column, weight_value,
                 lookup_index, output ready);
endinterface

interface oebs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] element_value;
   logic [5:0]  element_position;
   logic        last_element;
   logic        bad_index_seen;
   modport source (output valid, element_value, element_position, last_element,
                   bad_index_seen, input ready);
   modport sink (input valid, element_value, element_position, last_element,
                 bad_index_seen, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/oebs_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module oebs_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output      logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/oebs_datapath.sv -----
// Datapath: weight RAM, row scan counter, accumulator, float adder, output register.
`default_nettype none
module oebs_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire oebs_pkg::ctrl_type   ctrl,
   output      oebs_pkg::stat_type   stat,
   input  wire logic [9:0]           weight_row,
   input  wire logic [31:0]          weight_value,
   input  wire logic [31:0]          lookup_index,
   output      logic [31:0]          out_value,
   output      logic                 out_bad
);
   logic [oebs_pkg::ScanW-1:0] row_ff, row_in;
   logic [31:0] idx_ff;
   logic        hit_ff, hit_in, bad_ff, bad_in;
   logic [31:0] acc_ff [oebs_pkg::Dim];
   logic [31:0] rdata, sel_ff [oebs_pkg::Dim];
   logic [oebs_pkg::MemW-1:0] addr;
   logic        rd_match_ff;
   logic [oebs_pkg::ColW-1:0] rd_col_ff;

   // Address: write uses the request row; scan walks rows, column from controller.
   always_comb begin
      if (ctrl.mem_we)
         addr = {weight_row[oebs_pkg::RowW-1:0], ctrl.col};
      else
         addr = {row_ff[oebs_pkg::RowW-1:0], ctrl.col};
   end

   oebs_ram #(.Width(32), .Depth(oebs_pkg::MemDepth)) u_ram (
      .clock(clock), .we(ctrl.mem_we), .addr(addr), .wdata(weight_value), .rdata(rdata));

   // Scan reads one word per cycle; row advances after its last column.
   always_comb begin
      row_in = row_ff;
      hit_in = hit_ff;
      bad_in = bad_ff;
      if (ctrl.scan_start) begin
         row_in = '0;
         hit_in = 1'b0;
      end else if (ctrl.scan_step &&
                   (ctrl.col == oebs_pkg::ColW'(oebs_pkg::Dim - 1))) begin
         row_in = row_ff + 1'b1;
      end
      if (rd_match_ff) hit_in = 1'b1;
      if (ctrl.set_bad) bad_in = 1'b1;
      if (ctrl.emit_clear) bad_in = 1'b0;
   end

   assign stat.scan_last = (row_ff == oebs_pkg::ScanW'(oebs_pkg::NumRows - 1))
                           && (ctrl.col == oebs_pkg::ColW'(oebs_pkg::Dim - 1));
   assign stat.hit = hit_ff | rd_match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0; hit_ff <= 1'b0; bad_ff <= 1'b0; rd_match_ff <= 1'b0;
      end else begin
         row_ff <= row_in; hit_ff <= hit_in; bad_ff <= bad_in;
         rd_match_ff <= ctrl.scan_step &&
                        ({{(32 - oebs_pkg::ScanW){1'b0}}, row_ff} == idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.scan_start) idx_ff <= lookup_index;
      rd_col_ff <= ctrl.col;
      if (rd_match_ff) sel_ff[rd_col_ff] <= rdata;
   end

   // Accumulator: one element added per cycle during accumulate, cleared on emit.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < oebs_pkg::Dim; i++) acc_ff[i] <= 32'd0;
      end else if (ctrl.emit_clear) begin
         for (int i = 0; i < oebs_pkg::Dim; i++) acc_ff[i] <= 32'd0;
      end else if (ctrl.acc_en) begin
         acc_ff[ctrl.col] <= oebs_pkg::fadd(acc_ff[ctrl.col], sel_ff[ctrl.col]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_load) begin
         out_value <= acc_ff[ctrl.col];
         out_bad   <= bad_ff;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/oebs_ctrl.sv -----
// Controller: sequences write, scan, accumulate and emit.
`default_nettype none
module oebs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   oebs_req_if.sink                req,
   input  wire logic               rsp_ready,
   output      logic               rsp_valid,
   output      logic [5:0]         rsp_pos,
   output      logic               rsp_last,
   output      oebs_pkg::ctrl_type ctrl,
   input  wire oebs_pkg::stat_type stat
);
   localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DRAIN = 3'd2,
                          S_ACC = 3'd3, S_EMIT = 3'd4, S_OUT = 3'd5;
   logic [2:0] state_ff, state_in;
   logic [oebs_pkg::ColW-1:0] col_ff, col_in;
   logic valid_ff, valid_in, last_ff, last_in;
   logic [5:0] pos_ff, pos_in;
   logic acc_req;

   assign req.ready = (state_ff == S_IDLE);
   assign acc_req = req.valid && req.ready;

   always_comb begin
      state_in = state_ff; col_in = col_ff;
      valid_in = valid_ff; last_in = last_ff; pos_in = pos_ff;
      ctrl = '0;
      ctrl.col = col_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc_req) begin
               priority if (req.operation == oebs_pkg::OP_WRITE) begin
                  ctrl.col = req.weight_column[oebs_pkg::ColW-1:0];
                  ctrl.mem_we = ({26'd0, req.weight_column} < 32'(oebs_pkg::Dim)) &&
                                ({22'd0, req.weight_row} < 32'(oebs_pkg::NumRows));
               end else if (req.operation == oebs_pkg::OP_LOOKUP) begin
                  ctrl.scan_start = 1'b1;
                  col_in = '0;
                  state_in = S_SCAN;
               end else if (req.operation == oebs_pkg::OP_EMIT) begin
                  col_in = '0;
                  state_in = S_EMIT;
               end else begin
               end
            end
         end
         S_SCAN: begin
            // every cycle reads one word; datapath steps the row on the last column
            ctrl.scan_step = 1'b1;
            if (col_ff == oebs_pkg::ColW'(oebs_pkg::Dim - 1)) begin
               col_in = '0;
            end else begin
               col_in = col_ff + 1'b1;
            end
            if (stat.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // last read lands in the select buffer
            col_in = '0;
            state_in = S_ACC;
            if (!stat.hit) begin
               ctrl.set_bad = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ACC: begin
            ctrl.acc_en = 1'b1;
            col_in = col_ff + 1'b1;
            if (col_ff == oebs_pkg::ColW'(oebs_pkg::Dim - 1)) state_in = S_IDLE;
         end
         S_EMIT: begin
            ctrl.emit_load = 1'b1;
            valid_in = 1'b1;
            pos_in = 6'(col_ff);
            last_in = (col_ff == oebs_pkg::ColW'(oebs_pkg::Dim - 1));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  ctrl.emit_clear = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  col_in = col_ff + 1'b1;
                  state_in = S_EMIT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; col_ff <= '0; valid_ff <= 1'b0; last_ff <= 1'b0; pos_ff <= '0;
      end else begin
         state_ff <= state_in; col_ff <= col_in; valid_ff <= valid_in;
         last_ff <= last_in; pos_ff <= pos_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_pos   = pos_ff;
   assign rsp_last  = last_ff;
endmodule
`default_nettype wire

// ----- rtl/core/oblivious_embedding_bag_sum_unit.sv -----
// Top level: oblivious embedding-bag sum unit.
// Usage:
//  - req channel (valid/ready): operation 0 writes one weight word at
//    (weight_row, weight_column); 1 scans the whole table and adds the row
//    equal to lookup_index into the bag; 2 emits the bag.
//  - rsp channel: on emit, DIM transactions, positions 0..DIM-1, last_element
//    on the final one; bad_index_seen if any lookup in the bag hit no row.
//  - Write: the word is written as the request is accepted. Lookup: reads
//    every table word (single RAM port, one word per cycle), passes a drain
//    state, then adds the kept row through the one shared float adder; a lookup
//    matching no row skips the adds. Emit: each element waits for rsp ready.
//  - One request at a time; req_ready is high only while idle.
//  - Synchronous reset clears the accumulator, bad flag and control; the
//    weight table is not cleared and reads undefined until written.
//  - A stalled receiver holds the current response stable; the emit sequence
//    waits, and accumulator/flag clear only after the last transaction.
`default_nettype none
module oblivious_embedding_bag_sum_unit (
   input wire logic clock,
   input wire logic reset,
   oebs_req_if.sink   req,
   oebs_rsp_if.source rsp
);
   oebs_pkg::ctrl_type ctrl;
   oebs_pkg::stat_type stat;

   oebs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp_ready(rsp.ready),
      .rsp_valid(rsp.valid), .rsp_pos(rsp.element_position),
      .rsp_last(rsp.last_element), .ctrl(ctrl), .stat(stat));

   oebs_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .weight_row(req.weight_row), .weight_value(req.weight_value),
      .lookup_index(req.lookup_index), .out_value(rsp.element_value),
      .out_bad(rsp.bad_index_seen));

   // No new request while a response is pending.
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("req ready while response pending");
   // Table write never happens during a scan or emit.
   a_we_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.mem_we |-> req.ready) else $error("table write outside idle");
   // Last response ends the emit: ready returns next cycle after handoff.
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last_element) |=> req.ready)
      else $error("not idle after last element");
endmodule
`default_nettype wire
